/* rtl/rmq_pkg.sv */
package rmq_pkg;

  localparam int DEF_FRAC_BITS = 14;
  // quotient bits of each off-diagonal divide; magnitudes never exceed 2^15
  localparam int QUO_BITS = 16;

  localparam logic [1:0] IDX_X = 2'd0;
  localparam logic [1:0] IDX_Y = 2'd1;
  localparam logic [1:0] IDX_Z = 2'd2;
  localparam logic [1:0] IDX_W = 2'd3;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } mat_t;

  typedef struct packed {
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
  } quat_t;

  function automatic logic signed [15:0] sat17(input logic signed [16:0] v);
    logic signed [15:0] r;
    if (v > 17'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -17'sd32768) begin
      r = -16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

/* rtl/rmq_sqrt_step.sv */
module rmq_sqrt_step import rmq_pkg::*; #(
  parameter int NB = 16
) (
  input  logic [NB+1:0] rem_i,
  input  logic [NB-1:0] root_i,
  input  logic [1:0]    pair,
  output logic [NB+1:0] rem_o,
  output logic [NB-1:0] root_o
);

  logic [NB+1:0] rem_t;
  logic [NB+1:0] trial;

  // one root digit: bring down two radicand bits, try (root*4 + 1)
  always_comb begin
    rem_t = {rem_i[NB-1:0], pair};
    trial = {root_i, 2'b01};
    if (rem_t >= trial) begin
      rem_o  = rem_t - trial;
      root_o = {root_i[NB-2:0], 1'b1};
    end else begin
      rem_o  = rem_t;
      root_o = {root_i[NB-2:0], 1'b0};
    end
  end

endmodule

/* rtl/rmq_div_step.sv */
module rmq_div_step import rmq_pkg::*; #(
  parameter int XW = 44,
  parameter int DW = 18,
  parameter int SH = 0
) (
  input  logic [XW-1:0] rem_i,
  input  logic [DW-1:0] den,
  output logic [XW-1:0] rem_o,
  output logic          qbit
);

  logic [XW-1:0] dsh;

  // restoring step for quotient bit SH
  always_comb begin
    dsh = {{(XW-DW){1'b0}}, den} << SH;
    qbit = (rem_i >= dsh);
    rem_o = qbit ? rem_i - dsh : rem_i;
  end

endmodule

/* rtl/rotation_matrix_to_quaternion.sv */
// Path of a matrix word: stage 0, the square-root digit stages, the numerator prep stage,
//   the divide stages and the output register (NB = 16 digit stages at FRAC_BITS = 14).
// Throughput: one word per cycle unless the output stalls; the square-root digit
//   stages and the quotient-bit divide stages each handle one word per cycle.
// Reset: rst (synchronous, active high) clears every stage valid bit and the
//   output valid; the data registers are not reset.
module rotation_matrix_to_quaternion import rmq_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  mat_valid,
  output logic  mat_ready,
  input  mat_t  mat,
  output logic  quat_valid,
  input  logic  quat_ready,
  output quat_t quat
);

  // candidate width: holds one + 3 * 2^15 with sign
  localparam int CW   = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 3;
  // radicand = cand << (FRAC_BITS-2), cand positive
  localparam int NW   = CW - 1 + FRAC_BITS - 2;
  localparam int NB   = (NW + 1) / 2;     // root digits
  localparam int RW   = NB + 2;           // partial remainder
  localparam int DW   = NB + 2;           // divisor 4*v
  localparam int XW   = DW + QUO_BITS;    // divide remainder
  localparam int VW   = (NB > 16) ? NB : 16;
  localparam int LAST = NB + QUO_BITS + 1;

  typedef struct packed {
    logic [1:0]                   big;
    logic [2:0][16:0]             s;      // off-diagonal terms, ascending component order
    logic [2*NB-1:0]              nrad;
    logic [RW-1:0]                rem;
    logic [NB-1:0]                root;
    logic [2:0][XW-1:0]           dr;
    logic [2:0][QUO_BITS-1:0]     dq;
    logic [2:0]                   neg;
  } rec_t;

  rec_t         st  [0:LAST];
  logic [LAST:0]   vld;
  logic [LAST+1:0] en;

  // a stage advances when empty or when the stage after it advances
  assign en[LAST+1] = !quat_valid | quat_ready;
  assign mat_ready  = en[0];

  genvar k, l;
  generate
    for (k = 0; k <= LAST; k++) begin : g_en
      assign en[k] = !vld[k] | en[k+1];
    end
  endgenerate

  // ---------------- stage 0: candidates and pick ----------------
  logic signed [CW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22, one;
  logic signed [CW-1:0] cx, cy, cz, cw, cbig;
  logic signed [16:0]   a01p, a20p, a12p, a12m, a20m, a01m;
  rec_t                 n0;

  always_comb begin
    one = CW'(1) <<< FRAC_BITS;
    e00 = {{(CW-16){mat.m00[15]}}, mat.m00};
    e01 = {{(CW-16){mat.m01[15]}}, mat.m01};
    e02 = {{(CW-16){mat.m02[15]}}, mat.m02};
    e10 = {{(CW-16){mat.m10[15]}}, mat.m10};
    e11 = {{(CW-16){mat.m11[15]}}, mat.m11};
    e12 = {{(CW-16){mat.m12[15]}}, mat.m12};
    e20 = {{(CW-16){mat.m20[15]}}, mat.m20};
    e21 = {{(CW-16){mat.m21[15]}}, mat.m21};
    e22 = {{(CW-16){mat.m22[15]}}, mat.m22};
    cx = one + e00 - e11 - e22;
    cy = one - e00 + e11 - e22;
    cz = one - e00 - e11 + e22;
    cw = one + e00 + e11 + e22;

    a01p = {mat.m01[15], mat.m01} + {mat.m10[15], mat.m10};
    a20p = {mat.m20[15], mat.m20} + {mat.m02[15], mat.m02};
    a12p = {mat.m12[15], mat.m12} + {mat.m21[15], mat.m21};
    a12m = {mat.m12[15], mat.m12} - {mat.m21[15], mat.m21};
    a20m = {mat.m20[15], mat.m20} - {mat.m02[15], mat.m02};
    a01m = {mat.m01[15], mat.m01} - {mat.m10[15], mat.m10};

    n0 = '0;
    // strict compare: earliest candidate keeps a tie
    n0.big = IDX_X;
    cbig = cx;
    if (cy > cbig) begin
      n0.big = IDX_Y;
      cbig = cy;
    end
    if (cz > cbig) begin
      n0.big = IDX_Z;
      cbig = cz;
    end
    if (cw > cbig) begin
      n0.big = IDX_W;
      cbig = cw;
    end
    n0.nrad = {{(2*NB-(CW-1)){1'b0}}, cbig[CW-2:0]} << (FRAC_BITS - 2);

    case (n0.big)
      IDX_X: begin
        n0.s[0] = a01p; n0.s[1] = a20p; n0.s[2] = a12m;
      end
      IDX_Y: begin
        n0.s[0] = a01p; n0.s[1] = a12p; n0.s[2] = a20m;
      end
      IDX_Z: begin
        n0.s[0] = a20p; n0.s[1] = a12p; n0.s[2] = a01m;
      end
      default: begin
        n0.s[0] = a12m; n0.s[1] = a20m; n0.s[2] = a01m;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en[0]) begin
      vld[0] <= mat_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      st[0] <= n0;
    end
  end

  // ---------------- stages 1..LAST ----------------
  generate
    for (k = 1; k <= LAST; k++) begin : g_stage
      rec_t nx;

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k] <= 1'b0;
        end else if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end

      always_ff @(posedge clk) begin
        if (en[k]) begin
          st[k] <= nx;
        end
      end

      if (k <= NB) begin : g_sqrt
        // one root digit per stage, radicand consumed from the top
        logic [RW-1:0] rem_o;
        logic [NB-1:0] root_o;

        rmq_sqrt_step #(.NB(NB)) u_sq (
          .rem_i  (st[k-1].rem),
          .root_i (st[k-1].root),
          .pair   (st[k-1].nrad[2*NB-1 -: 2]),
          .rem_o  (rem_o),
          .root_o (root_o)
        );

        always_comb begin
          nx      = st[k-1];
          nx.rem  = rem_o;
          nx.root = root_o;
          nx.nrad = st[k-1].nrad << 2;
        end
      end else if (k == NB + 1) begin : g_prep
        // numerator magnitudes |s| << FRAC_BITS, signs kept aside
        logic [2:0][16:0] mag;

        always_comb begin
          nx = st[k-1];
          for (int i = 0; i < 3; i++) begin
            nx.neg[i] = st[k-1].s[i][16];
            mag[i]    = st[k-1].s[i][16] ? 17'(-st[k-1].s[i]) : st[k-1].s[i];
            nx.dr[i]  = {{(XW-17){1'b0}}, mag[i]} << FRAC_BITS;
            nx.dq[i]  = '0;
          end
        end
      end else begin : g_div
        localparam int SH = QUO_BITS - 1 - (k - NB - 2);
        logic [2:0][XW-1:0] rem_o;
        logic [2:0]         qbit;

        for (l = 0; l < 3; l++) begin : g_lane
          rmq_div_step #(.XW(XW), .DW(DW), .SH(SH)) u_dv (
            .rem_i (st[k-1].dr[l]),
            .den   ({st[k-1].root, 2'b00}),
            .rem_o (rem_o[l]),
            .qbit  (qbit[l])
          );
        end

        always_comb begin
          nx = st[k-1];
          for (int i = 0; i < 3; i++) begin
            nx.dr[i]     = rem_o[i];
            nx.dq[i][SH] = qbit[i];
          end
        end
      end
    end
  endgenerate

  // ---------------- output register ----------------
  logic [2:0][15:0] lane;
  logic [VW-1:0]    vz;
  logic [15:0]      vsat;
  quat_t            qn;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lane[i] = sat17(st[LAST].neg[i] ? -$signed({1'b0, st[LAST].dq[i]})
                                      :  $signed({1'b0, st[LAST].dq[i]}));
    end
    vz   = VW'(st[LAST].root);
    vsat = (vz > VW'(32767)) ? 16'h7fff : vz[15:0];
    case (st[LAST].big)
      IDX_X:   qn = '{qx: vsat,    qy: lane[0], qz: lane[1], qw: lane[2]};
      IDX_Y:   qn = '{qx: lane[0], qy: vsat,    qz: lane[1], qw: lane[2]};
      IDX_Z:   qn = '{qx: lane[0], qy: lane[1], qz: vsat,    qw: lane[2]};
      default: qn = '{qx: lane[0], qy: lane[1], qz: lane[2], qw: vsat};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quat_valid <= 1'b0;
    end else if (en[LAST+1]) begin
      quat_valid <= vld[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (en[LAST+1]) begin
      quat <= qn;
    end
  end

  // ---------------- checks ----------------
  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    (&vld && quat_valid && !quat_ready) |-> !mat_ready)
    else $error("pipeline full and stalled but input ready");

  a_radicand_nonzero: assert property (@(posedge clk) disable iff (rst)
    vld[0] |-> (st[0].nrad != '0))
    else $error("largest candidate not positive");

  a_root_floor: assert property (@(posedge clk) disable iff (rst)
    vld[NB+1] |-> (st[NB+1].root >= NB'(1 << (FRAC_BITS - 1))))
    else $error("root below half of one");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    vld[LAST] |-> ((st[LAST].dr[0] < XW'({st[LAST].root, 2'b00}))
               && (st[LAST].dr[1] < XW'({st[LAST].root, 2'b00}))
               && (st[LAST].dr[2] < XW'({st[LAST].root, 2'b00}))))
    else $error("divide remainder not below divisor");

endmodule

/* sim/tb_rotation_matrix_to_quaternion.sv */
`timescale 1ns / 100ps

module tb_rotation_matrix_to_quaternion;
  import rmq_pkg::*;

  localparam int FRAC = DEF_FRAC_BITS;
  localparam int ONE = 1 << FRAC;
  localparam int N_RANDOM = 1400;
  // drain time after the last expected word; leave generous slack beyond the pipeline depth
  localparam int DRAIN_CYCLES = 60;

  logic  clk;
  logic  rst;
  logic  mat_valid;
  logic  mat_ready;
  mat_t  mat;
  logic  quat_valid;
  logic  quat_ready;
  quat_t quat;

  rotation_matrix_to_quaternion #(.FRAC_BITS(FRAC)) dut (
    .clk(clk),
    .rst(rst),
    .mat_valid(mat_valid),
    .mat_ready(mat_ready),
    .mat(mat),
    .quat_valid(quat_valid),
    .quat_ready(quat_ready),
    .quat(quat)
  );

  mat_t  pending_mats[$];   // matrices waiting to be driven
  quat_t expected_quats[$]; // quaternions predicted for accepted matrices

  int n_sent = 0;
  int n_recv = 0;
  int n_mismatch = 0;
  int branch_hits[4] = '{default: 0};  // how often each component was the pivot

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor: Shepperd's method in fixed point
  // ---------------------------------------------------------------------------

  function automatic logic signed [15:0] clip16(input longint v);
    logic signed [15:0] r;
    if (v > 32767) begin
      r = 16'sh7fff;
    end else if (v < -32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // integer square root, result truncated
  function automatic longint root_floor(input longint n);
    longint rem;
    longint root;
    longint bitv;
    rem = n;
    root = 0;
    bitv = 64'sd1 <<< 62;
    while (bitv > rem) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >>> 1) + bitv;
      end else begin
        root = root >>> 1;
      end
      bitv = bitv >>> 2;
    end
    return root;
  endfunction

  // pivot component: the largest diagonal candidate, earliest wins ties
  function automatic logic [1:0] pivot_of(input mat_t m);
    longint cand[4];
    logic [1:0] big;
    cand[IDX_X] = ONE + m.m00 - m.m11 - m.m22;
    cand[IDX_Y] = ONE - m.m00 + m.m11 - m.m22;
    cand[IDX_Z] = ONE - m.m00 - m.m11 + m.m22;
    cand[IDX_W] = ONE + m.m00 + m.m11 + m.m22;
    big = IDX_X;
    for (int i = 1; i < 4; i++) begin
      if (cand[i] > cand[big]) big = i[1:0];
    end
    return big;
  endfunction

  function automatic quat_t quat_from_matrix(input mat_t m);
    longint cand;
    longint v;
    longint den;
    longint q[4];
    logic [1:0] big;
    quat_t r;
    big = pivot_of(m);
    case (big)
      IDX_X: cand = ONE + m.m00 - m.m11 - m.m22;
      IDX_Y: cand = ONE - m.m00 + m.m11 - m.m22;
      IDX_Z: cand = ONE - m.m00 - m.m11 + m.m22;
      default: cand = ONE + m.m00 + m.m11 + m.m22;
    endcase
    v = root_floor(cand <<< (FRAC - 2));
    den = 4 * v;
    q[big] = v;
    // SV signed division truncates toward zero
    case (big)
      IDX_X: begin
        q[IDX_Y] = ((longint'(m.m01) + m.m10) <<< FRAC) / den;
        q[IDX_Z] = ((longint'(m.m20) + m.m02) <<< FRAC) / den;
        q[IDX_W] = ((longint'(m.m12) - m.m21) <<< FRAC) / den;
      end
      IDX_Y: begin
        q[IDX_X] = ((longint'(m.m01) + m.m10) <<< FRAC) / den;
        q[IDX_Z] = ((longint'(m.m12) + m.m21) <<< FRAC) / den;
        q[IDX_W] = ((longint'(m.m20) - m.m02) <<< FRAC) / den;
      end
      IDX_Z: begin
        q[IDX_X] = ((longint'(m.m20) + m.m02) <<< FRAC) / den;
        q[IDX_Y] = ((longint'(m.m12) + m.m21) <<< FRAC) / den;
        q[IDX_W] = ((longint'(m.m01) - m.m10) <<< FRAC) / den;
      end
      default: begin
        q[IDX_X] = ((longint'(m.m12) - m.m21) <<< FRAC) / den;
        q[IDX_Y] = ((longint'(m.m20) - m.m02) <<< FRAC) / den;
        q[IDX_Z] = ((longint'(m.m01) - m.m10) <<< FRAC) / den;
      end
    endcase
    r.qx = clip16(q[IDX_X]);
    r.qy = clip16(q[IDX_Y]);
    r.qz = clip16(q[IDX_Z]);
    r.qw = clip16(q[IDX_W]);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic mat_t diag_mat(input int a, input int b, input int c);
    mat_t m;
    m = '0;
    m.m00 = a[15:0];
    m.m11 = b[15:0];
    m.m22 = c[15:0];
    return m;
  endfunction

  function automatic logic [15:0] small_off();
    return 16'($signed($urandom_range(0, 2 * ONE)) - ONE);
  endfunction

  // matrix whose diagonal favors a chosen pivot, off-diagonals random
  function automatic mat_t biased_mat(input logic [1:0] pick);
    mat_t m;
    m = {$urandom, $urandom, $urandom, $urandom, 16'($urandom)};
    m.m01 = small_off();
    m.m02 = small_off();
    m.m10 = small_off();
    m.m12 = small_off();
    m.m20 = small_off();
    m.m21 = small_off();
    m.m00 = 16'($signed($urandom_range(0, ONE)) * ((pick == IDX_X || pick == IDX_W) ? 1 : -1));
    m.m11 = 16'($signed($urandom_range(0, ONE)) * ((pick == IDX_Y || pick == IDX_W) ? 1 : -1));
    m.m22 = 16'($signed($urandom_range(0, ONE)) * ((pick == IDX_Z || pick == IDX_W) ? 1 : -1));
    return m;
  endfunction

  initial begin
    mat_t m;
    // identity: w pivot, other components zero
    pending_mats.push_back(diag_mat(ONE, ONE, ONE));
    // half-turns about each axis: x, y and z pivots
    pending_mats.push_back(diag_mat(ONE, -ONE, -ONE));
    pending_mats.push_back(diag_mat(-ONE, ONE, -ONE));
    pending_mats.push_back(diag_mat(-ONE, -ONE, ONE));
    // all-zero matrix: four-way tie, x wins
    pending_mats.push_back(diag_mat(0, 0, 0));
    // partial ties: y and z, x and y, then x, y and z
    pending_mats.push_back(diag_mat(-ONE, 0, 0));
    pending_mats.push_back(diag_mat(0, 0, -ONE));
    pending_mats.push_back(diag_mat(-ONE, -ONE, -ONE));
    // extreme fields everywhere
    pending_mats.push_back({9{16'h7fff}});
    pending_mats.push_back({9{16'h8000}});
    pending_mats.push_back({9{16'hffff}});
    // large off-diagonals with smallest pivot: drives the quotients to full scale
    m = diag_mat(0, 0, 0);
    m.m01 = 16'h7fff; m.m10 = 16'h7fff; m.m02 = 16'h8000; m.m20 = 16'h8000;
    m.m12 = 16'h7fff; m.m21 = 16'h8000;
    pending_mats.push_back(m);
    m.m12 = 16'h8000; m.m21 = 16'h7fff;
    pending_mats.push_back(m);
    m = diag_mat(-32768, -32768, -32768);
    m.m01 = 16'h7fff; m.m10 = 16'h8000;
    pending_mats.push_back(m);
    m = diag_mat(32767, -32768, -32768);
    m.m12 = 16'h7fff; m.m21 = 16'h8000;
    pending_mats.push_back(m);
    m = diag_mat(-32768, 32767, -32768);
    m.m20 = 16'h7fff; m.m02 = 16'h8000;
    pending_mats.push_back(m);
    m = diag_mat(-32768, -32768, 32767);
    m.m01 = 16'h8000; m.m10 = 16'h7fff;
    pending_mats.push_back(m);
    // random part: mostly pivot-steered matrices, the rest raw bits
    for (int i = 0; i < N_RANDOM; i++) begin
      if ($urandom_range(0, 9) < 6) begin
        m = biased_mat(2'($urandom_range(0, 3)));
      end else begin
        m = {$urandom, $urandom, $urandom, $urandom, 16'($urandom)};
      end
      pending_mats.push_back(m);
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: one matrix word per handshake, random gaps with idle-free bursts
  // ---------------------------------------------------------------------------

  int  send_gap;
  int  send_mode_left;
  logic send_burst;

  always @(posedge clk) begin
    if (rst) begin
      mat_valid <= 1'b0;
      mat <= '0;
      send_gap <= 0;
      send_mode_left <= 0;
      send_burst <= 1'b0;
    end else begin
      if (mat_valid && mat_ready) begin
        expected_quats.push_back(quat_from_matrix(mat));
        branch_hits[pivot_of(mat)]++;
        n_sent++;
      end
      if (!mat_valid || mat_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          mat_valid <= 1'b0;
        end else if (pending_mats.size() > 0) begin
          mat <= pending_mats.pop_front();
          mat_valid <= 1'b1;
          // switch between bursty and idle-filled stretches now and then
          if (send_mode_left == 0) begin
            send_burst <= ($urandom_range(0, 2) == 0);
            send_mode_left <= $urandom_range(20, 120);
          end else begin
            send_mode_left <= send_mode_left - 1;
          end
          send_gap <= send_burst ? 0 : $urandom_range(0, 8);
        end else begin
          mat_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random back-pressure, compares each quaternion word in order
  // ---------------------------------------------------------------------------

  int recv_stall;
  int recv_mode_left;
  logic recv_burst;

  always @(posedge clk) begin
    quat_t want;
    if (rst) begin
      quat_ready <= 1'b0;
      recv_stall <= 0;
      recv_mode_left <= 0;
      recv_burst <= 1'b0;
    end else begin
      if (quat_valid && quat_ready) begin
        n_recv++;
        if (expected_quats.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("%0t: unexpected quaternion word %h", $realtime, quat);
        end else begin
          want = expected_quats.pop_front();
          if (quat !== want) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display("%0t: word %0d expected x=%0d y=%0d z=%0d w=%0d got x=%0d y=%0d z=%0d w=%0d",
                       $realtime, n_recv - 1, want.qx, want.qy, want.qz, want.qw,
                       quat.qx, quat.qy, quat.qz, quat.qw);
          end
        end
      end
      // ready stays low while the stall count runs down; each ready cycle draws a new stall count
      if (recv_stall > 0) begin
        recv_stall <= recv_stall - 1;
        quat_ready <= 1'b0;
      end else begin
        quat_ready <= 1'b1;
        if (recv_mode_left == 0) begin
          recv_burst <= ($urandom_range(0, 2) == 0);
          recv_mode_left <= $urandom_range(20, 120);
        end else begin
          recv_mode_left <= recv_mode_left - 1;
        end
        recv_stall <= recv_burst ? 0 : $urandom_range(0, 8);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Reset, end of run
  // ---------------------------------------------------------------------------

  initial begin
    rst = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    wait (pending_mats.size() == 0 && !mat_valid);
    wait (expected_quats.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d matrices, got %0d quaternions, %0d mismatches.",
             n_sent, n_recv, n_mismatch);
    $display("Pivot counts x=%0d y=%0d z=%0d w=%0d.",
             branch_hits[IDX_X], branch_hits[IDX_Y], branch_hits[IDX_Z], branch_hits[IDX_W]);
    if (n_mismatch == 0 && expected_quats.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #5ms;
    $display("Timeout with %0d quaternions still expected.", expected_quats.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* filelist.f */
rtl/rmq_pkg.sv
rtl/rmq_sqrt_step.sv
rtl/rmq_div_step.sv
rtl/rotation_matrix_to_quaternion.sv
sim/tb_rotation_matrix_to_quaternion.sv
